// ===== rtl/core/vcfgp_pkg.sv =====
// ---------------------------------------------------------------------------
// vcfgp_pkg
// Shared constants, types and helpers for the VCF genotype line parser.
// ---------------------------------------------------------------------------
package vcfgp_pkg;

	// Sizing
	localparam int MAX_ALLELES = 8;
	localparam int MAX_SAMPLES = 4096;
	localparam int AC_W        = $clog2(MAX_ALLELES + 1);
	localparam int AI_W        = $clog2(MAX_ALLELES);
	localparam int COL_W       = 12;
	localparam int COL_CAP     = (MAX_SAMPLES - 1 > 4095) ? 4095 : MAX_SAMPLES - 1;
	localparam int POS_W       = 32;
	localparam int IDX_W       = 8;

	// Queue between front and back
	localparam int QDEPTH = 4;
	localparam int QA_W   = $clog2(QDEPTH);
	localparam int QC_W   = $clog2(QDEPTH + 1);

	// Field numbers within a data line
	localparam logic [3:0] FLD_POS    = 4'd1;
	localparam logic [3:0] FLD_REF    = 4'd3;
	localparam logic [3:0] FLD_ALT    = 4'd4;
	localparam logic [3:0] FLD_SAMPLE = 4'd9;

	// Special characters
	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [3:0] MASK_UNKNOWN = 4'hf;

	// Classified byte
	typedef struct packed {
		logic       eol;
		logic       tab;
		logic       comma;
		logic       digit;
		logic [3:0] dval;
		logic [3:0] nmask;
	} tok_t;

	// Nucleotide character to mask, either case
	function automatic logic [3:0] nuc_mask(input logic [7:0] c);
		logic [3:0] m;
		case (c)
			8'h41, 8'h61: m = 4'h1;
			8'h43, 8'h63: m = 4'h2;
			8'h47, 8'h67: m = 4'h4;
			8'h54, 8'h74: m = 4'h8;
			default:      m = MASK_UNKNOWN;
		endcase
		return m;
	endfunction

endpackage

// ===== rtl/core/vcfgp_front.sv =====
// ---------------------------------------------------------------------------
// vcfgp_front
// Accepts text bytes and classifies each one into a token for the queue.
// ---------------------------------------------------------------------------
module vcfgp_front import vcfgp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_byte,
	output logic       tok_valid,
	input  logic       tok_ready,
	output tok_t       tok
);

	tok_t tok_s1;
	logic v_s1;
	logic take;
	logic [3:0] dsub;

	assign in_ready  = !v_s1 || tok_ready;
	assign take      = in_valid && in_ready;
	assign tok_valid = v_s1;
	assign tok       = tok_s1;
	assign dsub      = 4'(char_byte - CH_ZERO);

	// Hold the valid flag of the classify stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	// Classify the accepted byte
	always_ff @(posedge clk) begin
		if (take) begin
			tok_s1.eol   <= (char_byte == CH_NL) || (char_byte == CH_NUL);
			tok_s1.tab   <= (char_byte == CH_TAB);
			tok_s1.comma <= (char_byte == CH_COMMA);
			tok_s1.digit <= (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
			tok_s1.dval  <= dsub;
			tok_s1.nmask <= nuc_mask(char_byte);
		end
	end

endmodule

// ===== rtl/core/vcfgp_queue.sv =====
// ---------------------------------------------------------------------------
// vcfgp_queue
// Short token queue that lets the front and the back stall independently.
// ---------------------------------------------------------------------------
module vcfgp_queue import vcfgp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  tok_t push_tok,
	output logic pop_valid,
	input  logic pop_ready,
	output tok_t pop_tok
);

	tok_t            mem_q [QDEPTH];
	logic [QA_W-1:0] wr_ptr_q;
	logic [QA_W-1:0] rd_ptr_q;
	logic [QC_W-1:0] count_q;
	logic            push;
	logic            pop;

	assign push_ready = (count_q != QC_W'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_tok    = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store tokens
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QC_W'(QDEPTH))
		else $error("queue occupancy above depth");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0 && count_q != QC_W'(QDEPTH)) |-> (wr_ptr_q != rd_ptr_q))
		else $error("queue pointers disagree with occupancy");
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue push lost");
`endif

endmodule

// ===== rtl/core/vcfgp_back.sv =====
// ---------------------------------------------------------------------------
// vcfgp_back
// Runs the line state machine on tokens and registers each sample result.
// ---------------------------------------------------------------------------
module vcfgp_back import vcfgp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tok_valid,
	output logic              tok_ready,
	input  tok_t              tok,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [POS_W-1:0]  position,
	output logic [COL_W-1:0]  sample_column,
	output logic [3:0]        allele_mask,
	output logic              last_sample
);

	// Index parse phases
	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_DIGITS = 2'd1;
	localparam logic [1:0] PH_DONE   = 2'd2;
	localparam logic [1:0] PH_BAD    = 2'd3;

	logic [3:0]       field_q;
	logic [POS_W-1:0] pos_q;
	logic [3:0]       table_q [MAX_ALLELES];
	logic [AC_W-1:0]  count_q;
	logic [IDX_W-1:0] index_q;
	logic [1:0]       phase_q;
	logic [COL_W-1:0] column_q;
	logic             out_valid_q;

	logic             take;
	logic             is_samp;
	logic             emit;
	logic [3:0]       sel_mask;
	logic [POS_W+3:0] pos_ext;
	logic [POS_W+3:0] pos_next;
	logic [11:0]      idx_ext;
	logic [11:0]      idx_next;
	logic             add_ok;
	logic             add_en;

	assign tok_ready = !out_valid_q || out_ready;
	assign take      = tok_valid && tok_ready;
	assign is_samp   = (field_q == FLD_SAMPLE);
	assign emit      = take && is_samp && (tok.eol || tok.tab);
	assign out_valid = out_valid_q;

	// Pick the allele mask for the sample that ends now
	always_comb begin
		sel_mask = MASK_UNKNOWN;
		if ((phase_q == PH_DIGITS || phase_q == PH_DONE) &&
		    ({{(IDX_W-AC_W){1'b0}}, count_q} > index_q)) begin
			sel_mask = table_q[index_q[AI_W-1:0]];
		end
	end

	// Decimal steps for POS and the allele index
	assign pos_ext  = {4'b0, pos_q};
	assign pos_next = (pos_ext << 3) + (pos_ext << 1) + (POS_W+4)'(tok.dval);
	assign idx_ext  = {4'b0, index_q};
	assign idx_next = (idx_ext << 3) + (idx_ext << 1) + 12'(tok.dval);

	// Decide whether this token adds an allele
	assign add_ok = (count_q < AC_W'(MAX_ALLELES));
	always_comb begin
		add_en = 1'b0;
		if (take && !tok.eol && !tok.tab && add_ok) begin
			case (field_q)
				FLD_REF: add_en = (count_q == '0);
				FLD_ALT: add_en = !tok.comma;
				default: add_en = 1'b0;
			endcase
		end
	end

	// Advance the line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q  <= '0;
			pos_q    <= '0;
			count_q  <= '0;
			index_q  <= '0;
			phase_q  <= PH_FIRST;
			column_q <= '0;
		end else if (take) begin
			if (tok.eol) begin
				field_q  <= '0;
				pos_q    <= '0;
				count_q  <= '0;
				index_q  <= '0;
				phase_q  <= PH_FIRST;
				column_q <= '0;
			end else if (tok.tab) begin
				if (is_samp) begin
					if (column_q < COL_W'(COL_CAP)) begin
						column_q <= column_q + 1'b1;
					end
					index_q <= '0;
					phase_q <= PH_FIRST;
				end else begin
					field_q <= field_q + 1'b1;
				end
			end else begin
				if (add_en) begin
					count_q <= count_q + 1'b1;
				end
				case (field_q)
					FLD_POS: begin
						if (tok.digit) begin
							pos_q <= (pos_next[POS_W+3:POS_W] != '0) ? '1 :
								pos_next[POS_W-1:0];
						end
					end
					FLD_SAMPLE: begin
						case (phase_q)
							PH_FIRST: begin
								if (tok.digit) begin
									index_q <= IDX_W'(tok.dval);
									phase_q <= PH_DIGITS;
								end else begin
									phase_q <= PH_BAD;
								end
							end
							PH_DIGITS: begin
								if (tok.digit) begin
									index_q <= (idx_next[11:IDX_W] != '0) ? '1 :
										idx_next[IDX_W-1:0];
								end else begin
									phase_q <= PH_DONE;
								end
							end
							default: begin
							end
						endcase
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Write the allele table
	always_ff @(posedge clk) begin
		if (add_en) begin
			table_q[count_q[AI_W-1:0]] <= tok.nmask;
		end
	end

	// Hold the result until the downstream transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			position      <= pos_q;
			sample_column <= column_q;
			allele_mask   <= sel_mask;
			last_sample   <= tok.eol;
		end
	end

`ifndef SYNTHESIS
	a_field_bound: assert property (@(posedge clk) disable iff (!arst_n)
		field_q <= FLD_SAMPLE)
		else $error("field number past sample field");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= AC_W'(MAX_ALLELES))
		else $error("allele count past table size");
	a_eol_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(take && tok.eol) |=> (field_q == '0 && count_q == '0 && column_q == '0))
		else $error("line state not cleared at line end");
	a_emit_only_samples: assert property (@(posedge clk) disable iff (!arst_n)
		(take && (tok.eol || tok.tab) && !is_samp) |=> !$rose(out_valid_q))
		else $error("result from a non-sample field");
`endif

endmodule

// ===== rtl/core/vcf_genotype_line_parser_core.sv =====
// ---------------------------------------------------------------------------
// vcf_genotype_line_parser_core
// Parses VCF data line bytes into one genotype allele mask per sample field.
// ---------------------------------------------------------------------------
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------
//  in      | in_valid / in_ready    | char_byte
//  out     | out_valid / out_ready  | position, sample_column, allele_mask,
//          |                        | last_sample
//
//  One byte is taken per cycle while in_ready is high; a result leaves once the byte
//  that ends its sample field has passed the classify register, queue and result register.
//  The back end holds its token while the result register is full and not
//  taken; the four-entry queue absorbs that stall before in_ready drops.
//  Reset clears all control state at once; no clearing pass follows.
//
module vcf_genotype_line_parser_core import vcfgp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        char_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [POS_W-1:0]  position,
	output logic [COL_W-1:0]  sample_column,
	output logic [3:0]        allele_mask,
	output logic              last_sample
);

	logic fq_valid;
	logic fq_ready;
	tok_t fq_tok;
	logic qb_valid;
	logic qb_ready;
	tok_t qb_tok;

	// Classify bytes
	vcfgp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_byte (char_byte),
		.tok_valid (fq_valid),
		.tok_ready (fq_ready),
		.tok       (fq_tok)
	);

	// Decouple front and back
	vcfgp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_tok   (fq_tok),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_tok    (qb_tok)
	);

	// Run the line state machine
	vcfgp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.tok_valid     (qb_valid),
		.tok_ready     (qb_ready),
		.tok           (qb_tok),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.position      (position),
		.sample_column (sample_column),
		.allele_mask   (allele_mask),
		.last_sample   (last_sample)
	);

endmodule
